// ----- design/xkb64_pkg.sv -----
// Package for the XOR-key base64 codec: beat types, register indexes,
// base64 character constants and alphabet conversion functions. No dependencies.
`default_nettype none

package xkb64_pkg;

  localparam int KeyBytesDef = 16;
  localparam int KeyLenW     = 5;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 64;
  localparam int AccW        = 16;
  localparam int PendW       = 4;
  localparam int MaxResults  = 4;
  localparam int CountW      = 3;

  localparam logic [CfgIdxW-1:0] RegDirection = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLength = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyLow    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyHigh   = 3'd3;

  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharPad   = 8'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic                        valid;
    logic [CountW-1:0]           count;
    out_item_t [MaxResults-1:0]  items;
  } batch_t;

  typedef struct packed {
    logic               direction;
    logic [KeyLenW-1:0] eff_len;
  } mode_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } dec_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = CharUpA + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CharLowA + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = CharZero + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = CharPlus;
    end else begin
      c = CharSlash;
    end
    return c;
  endfunction

  function automatic dec_t b64_decode(input logic [7:0] c);
    dec_t d;
    logic [7:0] t;
    d = '0;
    t = '0;
    if (c >= CharUpA && c <= CharUpZ) begin
      t = c - CharUpA;
      d.ok = 1'b1;
    end else if (c >= CharLowA && c <= CharLowZ) begin
      t = c - CharLowA + 8'd26;
      d.ok = 1'b1;
    end else if (c >= CharZero && c <= CharNine) begin
      t = c - CharZero + 8'd52;
      d.ok = 1'b1;
    end else if (c == CharPlus) begin
      t = 8'd62;
      d.ok = 1'b1;
    end else if (c == CharSlash) begin
      t = 8'd63;
      d.ok = 1'b1;
    end
    d.val = t[5:0];
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- design/xkb64_cfg.sv -----
// Configuration registers: direction, key length (clamped), key bytes.
// Depends on xkb64_pkg.
`default_nettype none

module xkb64_cfg import xkb64_pkg::*; #(
  parameter int KEY_BYTES = KeyBytesDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [CfgDataW-1:0]       cfg_data_i,
  output mode_t                          mode_o,
  output logic [KEY_BYTES*8-1:0]         key_o
);

  localparam logic [KeyLenW-1:0] MaxLen = KeyLenW'(KEY_BYTES);

  logic                   dir_q;
  logic [KeyLenW-1:0]     klen_q;
  logic [KEY_BYTES*8-1:0] key_q;
  logic                   wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= 1'b0;
      klen_q <= KeyLenW'(1);
      key_q  <= '0;
    end else if (wr) begin
      case (cfg_index_i)
        RegDirection: dir_q  <= cfg_data_i[0];
        RegKeyLength: klen_q <= cfg_data_i[KeyLenW-1:0];
        RegKeyLow: begin
          for (int b = 0; b < KEY_BYTES; b++) begin
            if (b < 8) key_q[b*8 +: 8] <= cfg_data_i[(b%8)*8 +: 8];
          end
        end
        RegKeyHigh: begin
          for (int b = 0; b < KEY_BYTES; b++) begin
            if (b >= 8) key_q[b*8 +: 8] <= cfg_data_i[(b%8)*8 +: 8];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_o.direction = dir_q;
    if (klen_q == '0) begin
      mode_o.eff_len = KeyLenW'(1);
    end else if (klen_q > MaxLen) begin
      mode_o.eff_len = MaxLen;
    end else begin
      mode_o.eff_len = klen_q;
    end
  end

  assign key_o = key_q;

endmodule

`default_nettype wire

// ----- design/xkb64_core.sv -----
// Input register, codec state and single-pass encode/decode logic that
// builds up to four result beats per item. Depends on xkb64_pkg.
`default_nettype none

module xkb64_core import xkb64_pkg::*; #(
  parameter int KEY_BYTES = KeyBytesDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,
  input  wire mode_t                 mode_i,
  input  wire logic [KEY_BYTES*8-1:0] key_i,
  input  wire logic                  can_load_i,
  output batch_t                     batch_o
);

  localparam int KeyPosW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  logic                 in_vld_q;
  in_item_t             in_q;
  logic [AccW-1:0]      acc_q, acc_d;
  logic [PendW-1:0]     pend_q, pend_d;
  logic [KeyPosW-1:0]   kpos_q, kpos_d;
  logic [1:0]           cm_q, cm_d;
  logic                 stop_q, stop_d;

  logic [KeyPosW-1:0]   pos_eff, pos_next;
  logic [KeyLenW-1:0]   pos_inc;
  logic [7:0]           key_byte;
  logic [AccW-1:0]      acc_x, sh;
  logic [4:0]           p;
  logic [1:0]           cm;
  logic [CountW-1:0]    n, nm1;
  dec_t                 dec;
  out_item_t [MaxResults-1:0] items;
  logic                 fire, accept;

  always_comb begin
    pos_eff  = (KeyLenW'(kpos_q) >= mode_i.eff_len) ? '0 : kpos_q;
    key_byte = key_i[pos_eff*8 +: 8];
    pos_inc  = KeyLenW'(pos_eff) + KeyLenW'(1);
    pos_next = (pos_inc >= mode_i.eff_len) ? '0 : KeyPosW'(pos_inc);

    acc_d  = acc_q;
    pend_d = pend_q;
    kpos_d = kpos_q;
    cm_d   = cm_q;
    stop_d = stop_q;
    items  = '0;
    n      = '0;
    acc_x  = acc_q;
    p      = {1'b0, pend_q};
    sh     = '0;
    cm     = cm_q;
    dec    = b64_decode(in_q.data_byte);

    if (!mode_i.direction) begin
      acc_x = {acc_q[7:0], in_q.data_byte ^ key_byte};
      p     = {1'b0, pend_q} + 5'd8;
      for (int i = 0; i < 2; i++) begin
        if (p >= 5'd6) begin
          sh = acc_x >> (p - 5'd6);
          items[n[1:0]] = '{out_byte: b64_char(sh[5:0]), has_data: 1'b1, last_out: 1'b0};
          n  = n + 3'd1;
          p  = p - 5'd6;
          cm = cm + 2'd1;
        end
      end
      if (in_q.last_in) begin
        if (p != 5'd0) begin
          sh = acc_x << (5'd6 - p);
          items[n[1:0]] = '{out_byte: b64_char(sh[5:0]), has_data: 1'b1, last_out: 1'b0};
          n  = n + 3'd1;
          cm = cm + 2'd1;
        end
        for (int i = 0; i < 3; i++) begin
          if (cm != 2'd0 && n < 3'd4) begin
            items[n[1:0]] = '{out_byte: CharPad, has_data: 1'b1, last_out: 1'b0};
            n  = n + 3'd1;
            cm = cm + 2'd1;
          end
        end
      end
      acc_d  = acc_x;
      pend_d = p[PendW-1:0];
      kpos_d = pos_next;
      cm_d   = cm;
    end else begin
      if (!stop_q) begin
        if (!dec.ok) begin
          stop_d = 1'b1;
        end else begin
          acc_x = {acc_q[9:0], dec.val};
          p     = {1'b0, pend_q} + 5'd6;
          acc_d = acc_x;
          if (p >= 5'd8) begin
            sh = acc_x >> (p - 5'd8);
            items[0] = '{out_byte: sh[7:0] ^ key_byte, has_data: 1'b1, last_out: 1'b0};
            n      = 3'd1;
            p      = p - 5'd8;
            kpos_d = pos_next;
          end
          pend_d = p[PendW-1:0];
        end
      end
      if (in_q.last_in && n == '0) begin
        items[0] = '{out_byte: 8'h00, has_data: 1'b0, last_out: 1'b0};
        n = 3'd1;
      end
    end

    nm1 = n - 3'd1;
    if (in_q.last_in) begin
      items[nm1[1:0]].last_out = 1'b1;
      acc_d  = '0;
      pend_d = '0;
      kpos_d = '0;
      cm_d   = '0;
      stop_d = 1'b0;
    end
  end

  assign fire       = in_vld_q & ((n == '0) | can_load_i);
  assign in_stall_o = in_vld_q & ~fire;
  assign accept     = in_valid_i & ~in_stall_o;

  assign batch_o.valid = fire & (n != '0);
  assign batch_o.count = n;
  assign batch_o.items = items;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      acc_q    <= '0;
      pend_q   <= '0;
      kpos_q   <= '0;
      cm_q     <= '0;
      stop_q   <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        acc_q  <= acc_d;
        pend_q <= pend_d;
        kpos_q <= kpos_d;
        cm_q   <= cm_d;
        stop_q <= stop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
  end

  // bit count stays even in both directions
  a_pend_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q[0] == 1'b0) else $error("odd pending bit count");

  // a finished message leaves no residue
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_q.last_in |=> acc_q == '0 && pend_q == '0 && cm_q == '0 && stop_q == 1'b0)
    else $error("state not cleared after last beat");

endmodule

`default_nettype wire

// ----- design/xkb64_outq.sv -----
// Result queue: holds up to four result beats of one item and drains them
// one per cycle while the output is not stalled; the head entry drives the output port. Depends on xkb64_pkg.
`default_nettype none

module xkb64_outq import xkb64_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire batch_t  batch_i,
  output logic         can_load_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output out_item_t    out_data_o
);

  out_item_t [MaxResults-1:0] res_q, res_d;
  logic [CountW-1:0]          cnt_q, cnt_d;
  logic                       pop;

  assign pop        = (cnt_q != '0) & ~out_stall_i;
  assign can_load_o = (cnt_q == '0) | ((cnt_q == CountW'(1)) & pop);

  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    if (batch_i.valid) begin
      res_d = batch_i.items;
      cnt_d = batch_i.count;
    end else if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
      cnt_d = cnt_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = res_q[0];

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(MaxResults)) else $error("queue count out of range");

  // a batch only lands once the previous one is drained or its last beat is popping
  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    batch_i.valid |-> can_load_o && batch_i.count != '0 &&
                      batch_i.count <= CountW'(MaxResults))
    else $error("batch loaded over pending results");

endmodule

`default_nettype wire

// ----- design/xor_key_base64_codec.sv -----
// Top level of the XOR-key base64 codec: config registers, codec core and
// result queue. Depends on xkb64_pkg, xkb64_cfg, xkb64_core, xkb64_outq.
//
//   channel | handshake               | payload
//   --------+-------------------------+---------------------------------
//   in      | in_valid_i / in_stall_o | in_data_i  (data_byte, last_in)
//   out     | out_valid_o/out_stall_i | out_data_o (out_byte, has_data, last_out)
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An item waits in the input register, where all its results are formed at once;
// they reach the output port in the cycle after the item leaves it.
// The result queue drains one beat per cycle while the output is not stalled; an
// encoded byte yields about 4/3 characters, a decoded character at most one byte.
// Output stall holds the queue; the input stalls once the queue cannot take
// the next item's results. Reset clears codec state and config to defaults.
`default_nettype none

module xor_key_base64_codec import xkb64_pkg::*; #(
  parameter int KEY_BYTES = KeyBytesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  mode_t                  mode;
  logic [KEY_BYTES*8-1:0] key;
  batch_t                 batch;
  logic                   can_load;

  xkb64_cfg #(.KEY_BYTES(KEY_BYTES)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mode_o      (mode),
    .key_o       (key)
  );

  xkb64_core #(.KEY_BYTES(KEY_BYTES)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .mode_i     (mode),
    .key_i      (key),
    .can_load_i (can_load),
    .batch_o    (batch)
  );

  xkb64_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .batch_i     (batch),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
